@@ rtl/core/lrtc_pkg.sv @@
// shared types, codes and constant-divide helpers for the latched rtc block
package lrtc_pkg;

  // request opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LATCH = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // register selects
  localparam logic [2:0] REG_SEC    = 3'd0;
  localparam logic [2:0] REG_MIN    = 3'd1;
  localparam logic [2:0] REG_HOUR   = 3'd2;
  localparam logic [2:0] REG_DAY_LO = 3'd3;
  localparam logic [2:0] REG_DAY_HI = 3'd4;

  // bit positions in the day-high register
  localparam int DAYHI_DAY8_BIT  = 0;
  localparam int DAYHI_HALT_BIT  = 6;
  localparam int DAYHI_CARRY_BIT = 7;

  // reciprocal multipliers for 8-bit operands
  localparam logic [15:0] DIV60_MUL   = 16'd137;
  localparam int          DIV60_SHIFT = 13;
  localparam logic [15:0] DIV24_MUL   = 16'd171;
  localparam int          DIV24_SHIFT = 12;

  localparam logic [7:0] SECS_PER_MIN = 8'd60;
  localparam logic [7:0] HOURS_PER_DAY = 8'd24;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] reg_select;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
  } rsp_t;

  // quotient of an 8-bit value by 60, exact for 0..255
  function automatic logic [2:0] div60(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * DIV60_MUL;
    return p[DIV60_SHIFT +: 3];
  endfunction

  // quotient of an 8-bit value by 24, exact for 0..255
  function automatic logic [3:0] div24(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * DIV24_MUL;
    return p[DIV24_SHIFT +: 4];
  endfunction

endpackage

@@ rtl/core/lrtc_stream_if.sv @@
// valid/ready channel carrying one payload struct
interface lrtc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/latched_rtc_counter_registers.sv @@
// top level: input register, clock engine and result register
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-------------
//  req     | in  | opcode, reg_select, write_data   | valid/ready
//  rsp     | out | read_data (one per request)      | valid/ready
//
// one request per cycle while results are taken; a result passes the input
// register, then the result register, over the combinational normalize path.
// rst is synchronous: it clears the clock, the latch and both handshake stages.
// a stalled result holds while a further request may still enter the input
// register; the input stalls only when both stages are full.
module latched_rtc_counter_registers (
  input logic                    clk,
  input logic                    rst,
  lrtc_stream_if.sink            req,
  lrtc_stream_if.source          rsp
);
  import lrtc_pkg::*;

  logic       s1_valid;
  req_t       s1_req;
  logic       rsp_valid;
  logic [7:0] rsp_read_data;
  logic [7:0] eng_read_data;
  logic       advance;
  logic       req_take;

  // stage handshake
  assign advance   = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign req_take  = req.valid && req.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_req <= req.data;
    end
  end

  lrtc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .exec      (advance),
    .req       (s1_req),
    .read_data (eng_read_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_read_data <= eng_read_data;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.data.read_data = rsp_read_data;

endmodule

@@ rtl/core/lrtc_engine.sv @@
// clock state, latch copy and the per-request update and read logic
module lrtc_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          exec,
  input  lrtc_pkg::req_t req,
  output logic [7:0]    read_data
);
  import lrtc_pkg::*;

  logic [5:0] live_seconds, live_seconds_next;
  logic [5:0] live_minutes, live_minutes_next;
  logic [4:0] live_hours, live_hours_next;
  logic [8:0] live_days, live_days_next;
  logic       halted, halted_next;
  logic       day_carry, day_carry_next;
  logic [7:0] held_seconds, held_seconds_next;
  logic [7:0] held_minutes, held_minutes_next;
  logic [7:0] held_hours, held_hours_next;
  logic [8:0] held_days, held_days_next;

  logic       do_settle;
  logic [7:0] sec_in, min_in, hr_in;
  logic [2:0] q_sec, q_min;
  logic [3:0] q_hr;
  logic [7:0] sec_rem, min_sum, min_rem, hr_sum, hr_rem;
  logic [9:0] day_sum;

  // normalization chain: seconds -> minutes -> hours -> days
  always_comb begin
    q_sec   = div60(sec_in);
    sec_rem = sec_in - 8'(q_sec) * SECS_PER_MIN;
    // minutes operand is only large when seconds carry nothing
    min_sum = min_in + 8'(q_sec);
    q_min   = div60(min_sum);
    min_rem = min_sum - 8'(q_min) * SECS_PER_MIN;
    hr_sum  = hr_in + 8'(q_min);
    q_hr    = div24(hr_sum);
    hr_rem  = hr_sum - 8'(q_hr) * HOURS_PER_DAY;
    day_sum = {1'b0, live_days} + 10'(q_hr);
  end

  // request decode and next-state selection
  always_comb begin
    live_seconds_next = live_seconds;
    live_minutes_next = live_minutes;
    live_hours_next   = live_hours;
    live_days_next    = live_days;
    halted_next       = halted;
    day_carry_next    = day_carry;
    held_seconds_next = held_seconds;
    held_minutes_next = held_minutes;
    held_hours_next   = held_hours;
    held_days_next    = held_days;
    sec_in    = {2'b00, live_seconds};
    min_in    = {2'b00, live_minutes};
    hr_in     = {3'b000, live_hours};
    do_settle = 1'b0;
    read_data = '0;

    unique case (req.opcode)
      OP_TICK: begin
        if (!halted) begin
          do_settle = 1'b1;
          sec_in    = {2'b00, live_seconds} + 8'd1;
        end
      end
      OP_LATCH: begin
        held_seconds_next = {2'b00, live_seconds};
        held_minutes_next = {2'b00, live_minutes};
        held_hours_next   = {3'b000, live_hours};
        held_days_next    = live_days;
      end
      OP_READ: begin
        unique case (req.reg_select)
          REG_SEC:    read_data = held_seconds;
          REG_MIN:    read_data = held_minutes;
          REG_HOUR:   read_data = held_hours;
          REG_DAY_LO: read_data = held_days[7:0];
          REG_DAY_HI: begin
            read_data[DAYHI_DAY8_BIT]  = held_days[8];
            read_data[DAYHI_HALT_BIT]  = halted;
            read_data[DAYHI_CARRY_BIT] = day_carry;
          end
          default:    read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (req.reg_select)
          REG_SEC: begin
            held_seconds_next = req.write_data;
            sec_in    = req.write_data;
            do_settle = 1'b1;
          end
          REG_MIN: begin
            held_minutes_next = req.write_data;
            min_in    = req.write_data;
            do_settle = 1'b1;
          end
          REG_HOUR: begin
            held_hours_next = req.write_data;
            hr_in     = req.write_data;
            do_settle = 1'b1;
          end
          REG_DAY_LO: begin
            held_days_next = {held_days[8], req.write_data};
            live_days_next = {held_days[8], req.write_data};
          end
          REG_DAY_HI: begin
            held_days_next = {req.write_data[DAYHI_DAY8_BIT], held_days[7:0]};
            live_days_next = {req.write_data[DAYHI_DAY8_BIT], held_days[7:0]};
            halted_next    = req.write_data[DAYHI_HALT_BIT];
            day_carry_next = req.write_data[DAYHI_CARRY_BIT];
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // apply normalized live time; day overflow wraps and sets carry
    if (do_settle) begin
      live_seconds_next = sec_rem[5:0];
      live_minutes_next = min_rem[5:0];
      live_hours_next   = hr_rem[4:0];
      live_days_next    = day_sum[8:0];
      if (day_sum[9]) begin
        day_carry_next = 1'b1;
      end
    end
  end

  // state registers, updated once per executed request
  always_ff @(posedge clk) begin
    if (rst) begin
      live_seconds <= '0;
      live_minutes <= '0;
      live_hours   <= '0;
      live_days    <= '0;
      halted       <= 1'b0;
      day_carry    <= 1'b0;
      held_seconds <= '0;
      held_minutes <= '0;
      held_hours   <= '0;
      held_days    <= '0;
    end else if (exec) begin
      live_seconds <= live_seconds_next;
      live_minutes <= live_minutes_next;
      live_hours   <= live_hours_next;
      live_days    <= live_days_next;
      halted       <= halted_next;
      day_carry    <= day_carry_next;
      held_seconds <= held_seconds_next;
      held_minutes <= held_minutes_next;
      held_hours   <= held_hours_next;
      held_days    <= held_days_next;
    end
  end

endmodule

@@ rtl/core/lrtc_checker.sv @@
// port-level checks for the latched rtc block and their bind
module lrtc_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_data
);

  // no result right after reset
  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // stalled result holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
    else $error("stalled result changed");

  // input never stalls while the output stage is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request stalled with empty output");

  // every taken request shows a result after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 rsp_valid)
    else $error("result missing after request");

endmodule

bind latched_rtc_counter_registers lrtc_checker u_lrtc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.data.read_data)
);
